// ----- hw/rtl/rsp_pkg.sv -----
// rsp_pkg: shared types, codes and constants for the rsp packet receiver
// no dependencies; used by every module of the block by scoped names
`timescale 1ns / 1ps

package rsp_pkg;

    localparam int BUF_DEPTH = 512;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int LEN_W     = 9;
    localparam int IDX_W     = 9;
    localparam int JOB_DEPTH = 4;
    localparam int JPTR_W    = $clog2(JOB_DEPTH);

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] HEX_BAD   = 8'hFF;

    localparam logic       CMD_BYTE = 1'b0;
    localparam logic       CMD_READ = 1'b1;

    localparam logic [1:0] OUT_SEND   = 2'd0;
    localparam logic [1:0] OUT_ACCEPT = 2'd1;
    localparam logic [1:0] OUT_READ   = 2'd2;

    localparam logic [1:0] START_SEQ  = 2'd3;
    localparam logic [1:0] START_NONE = 2'd0;

    typedef struct packed {
        logic             command;
        logic [7:0]       rx_byte;
        logic [IDX_W-1:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic [1:0]       payload_start;
        logic [LEN_W-1:0] payload_length;
        logic             last;
    } t_out_item;

    typedef enum logic [1:0] {
        JOB_READ = 2'd0,
        JOB_NAK  = 2'd1,
        JOB_ACK  = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind        kind;
        logic [7:0]       data;
        logic             seq;
        logic [7:0]       seq0;
        logic [7:0]       seq1;
        logic [LEN_W-1:0] len;
    } t_job;

    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = HEX_BAD;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end
        return v;
    endfunction

endpackage

// ----- hw/rtl/rsp_front.sv -----
// rsp_front: accepts items, runs the framing and checksum state machine,
// owns the packet store and issues one job per item that has results; uses rsp_pkg
`timescale 1ns / 1ps

module rsp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rsp_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_job_vld,
    output rsp_pkg::t_job     o_job,
    input  logic              i_job_full
);

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_BODY = 4'b0010,
        PH_HI   = 4'b0100,
        PH_LO   = 4'b1000
    } t_phase;

    t_phase                      r_phase, n_phase;
    logic [7:0]                  r_sum, n_sum;
    logic [rsp_pkg::ADDR_W-1:0]  r_count, n_count;
    logic [7:0]                  r_hi, n_hi;
    logic [7:0]                  r_s0, r_s1, r_s2;

    logic [7:0]                  r_mem [rsp_pkg::BUF_DEPTH];
    logic [7:0]                  r_rdata;
    logic                        r_rd_zero;

    logic                        r_st_vld, n_st_vld;
    rsp_pkg::t_job               r_job, n_job;

    logic                        accept;
    logic                        has_job;
    logic                        wr_en;
    logic [rsp_pkg::ADDR_W-1:0]  wr_addr;
    logic [7:0]                  wr_data;
    logic [rsp_pkg::ADDR_W-1:0]  inc_count;
    logic [rsp_pkg::ADDR_W-1:0]  rd_addr;
    logic [7:0]                  xsum;
    logic [7:0]                  ch;
    logic [7:0]                  hex_ch;

    assign o_full  = r_st_vld && i_job_full;
    assign accept  = i_push && !o_full;
    assign ch      = i_item.rx_byte;
    assign hex_ch  = rsp_pkg::hex_value(ch);
    assign inc_count = r_count + rsp_pkg::ADDR_W'(1);
    assign xsum    = r_hi + hex_ch;
    assign rd_addr = rsp_pkg::ADDR_W'(i_item.read_index);

    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        n_count = r_count;
        n_hi    = r_hi;
        wr_en   = 1'b0;
        wr_addr = r_count;
        wr_data = ch;
        has_job = 1'b0;
        n_job   = '0;
        n_job.kind = rsp_pkg::JOB_READ;
        if (i_item.command == rsp_pkg::CMD_READ) begin
            has_job = 1'b1;
        end else begin
            case (r_phase)
                PH_HUNT: begin
                    if (ch == rsp_pkg::CH_DOLLAR) begin
                        n_phase = PH_BODY;
                        n_sum   = '0;
                        n_count = '0;
                    end
                end
                PH_BODY: begin
                    if (ch == rsp_pkg::CH_DOLLAR) begin
                        n_sum   = '0;
                        n_count = '0;
                    end else if (ch == rsp_pkg::CH_HASH) begin
                        wr_en   = 1'b1;
                        wr_data = '0;
                        n_phase = PH_HI;
                    end else begin
                        wr_en   = 1'b1;
                        n_sum   = r_sum + ch;
                        n_count = inc_count;
                        // last entry is never written; reads at or beyond it return zero
                        if (inc_count == rsp_pkg::ADDR_W'(rsp_pkg::BUF_DEPTH - 1)) begin
                            n_phase = PH_HUNT;
                        end
                    end
                end
                PH_HI: begin
                    n_hi    = {hex_ch[3:0], 4'h0};
                    n_phase = PH_LO;
                end
                PH_LO: begin
                    n_phase = PH_HUNT;
                    has_job = 1'b1;
                    if (xsum != r_sum) begin
                        n_job.kind = rsp_pkg::JOB_NAK;
                    end else begin
                        n_job.kind = rsp_pkg::JOB_ACK;
                        n_job.seq0 = r_s0;
                        n_job.seq1 = r_s1;
                        if (r_count >= rsp_pkg::ADDR_W'(3) && r_s2 == rsp_pkg::CH_COLON) begin
                            n_job.seq = 1'b1;
                            n_job.len = rsp_pkg::LEN_W'(r_count - rsp_pkg::ADDR_W'(3));
                        end else begin
                            n_job.len = rsp_pkg::LEN_W'(r_count);
                        end
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_comb begin
        n_st_vld = r_st_vld;
        if (accept) begin
            n_st_vld = has_job;
        end else if (r_st_vld && !i_job_full) begin
            n_st_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_sum    <= '0;
            r_count  <= '0;
            r_hi     <= '0;
            r_st_vld <= 1'b0;
        end else begin
            r_st_vld <= n_st_vld;
            if (accept) begin
                r_phase <= n_phase;
                r_sum   <= n_sum;
                r_count <= n_count;
                r_hi    <= n_hi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
            if (wr_en) begin
                r_mem[wr_addr] <= wr_data;
                if (wr_addr == rsp_pkg::ADDR_W'(0)) begin
                    r_s0 <= wr_data;
                end
                if (wr_addr == rsp_pkg::ADDR_W'(1)) begin
                    r_s1 <= wr_data;
                end
                if (wr_addr == rsp_pkg::ADDR_W'(2)) begin
                    r_s2 <= wr_data;
                end
            end
            if (i_item.command == rsp_pkg::CMD_READ) begin
                r_rdata   <= r_mem[rd_addr];
                r_rd_zero <= 32'(i_item.read_index) >= 32'(rsp_pkg::BUF_DEPTH - 1);
            end
        end
    end

    always_comb begin
        o_job_vld = r_st_vld;
        o_job     = r_job;
        if (r_job.kind == rsp_pkg::JOB_READ) begin
            o_job.data = r_rd_zero ? 8'h00 : r_rdata;
        end
    end

endmodule

// ----- hw/rtl/rsp_job_fifo.sv -----
// rsp_job_fifo: short job queue between the front and back parts
// depends on rsp_pkg for the job type and depth
`timescale 1ns / 1ps

module rsp_job_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rsp_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output rsp_pkg::t_job o_job,
    output logic          o_empty
);

    rsp_pkg::t_job               r_q [rsp_pkg::JOB_DEPTH];
    logic [rsp_pkg::JPTR_W-1:0]  r_wp, r_rp;
    logic [rsp_pkg::JPTR_W:0]    r_cnt;
    logic                        do_push, do_pop;

    assign o_full  = r_cnt == (rsp_pkg::JPTR_W + 1)'(rsp_pkg::JOB_DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + rsp_pkg::JPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + rsp_pkg::JPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (rsp_pkg::JPTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (rsp_pkg::JPTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_job;
        end
    end

endmodule

// ----- hw/rtl/rsp_back.sv -----
// rsp_back: expands each job into its result transfers into an output register
// depends on rsp_pkg for job and result types
`timescale 1ns / 1ps

module rsp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_empty,
    input  rsp_pkg::t_job      i_job,
    output logic               o_job_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output rsp_pkg::t_out_item o_item
);

    logic [1:0]          r_idx;
    logic [1:0]          last_idx;
    logic                r_out_vld;
    rsp_pkg::t_out_item  r_out;
    rsp_pkg::t_out_item  res;
    logic                can_load;
    logic                load;

    assign o_empty  = !r_out_vld;
    assign o_item   = r_out;
    assign can_load = !r_out_vld || i_pop;
    assign load     = can_load && !i_job_empty;
    assign o_job_pop = load && (r_idx == last_idx);

    always_comb begin
        last_idx = 2'd0;
        if (i_job.kind == rsp_pkg::JOB_ACK) begin
            last_idx = i_job.seq ? 2'd3 : 2'd1;
        end
    end

    always_comb begin
        res      = '0;
        res.kind = rsp_pkg::OUT_SEND;
        res.last = r_idx == last_idx;
        case (i_job.kind)
            rsp_pkg::JOB_READ: begin
                res.kind = rsp_pkg::OUT_READ;
                res.data = i_job.data;
            end
            rsp_pkg::JOB_NAK: begin
                res.data = rsp_pkg::CH_MINUS;
            end
            rsp_pkg::JOB_ACK: begin
                if (r_idx == 2'd0) begin
                    res.data = rsp_pkg::CH_PLUS;
                end else if (r_idx == last_idx) begin
                    res.kind           = rsp_pkg::OUT_ACCEPT;
                    res.payload_start  = i_job.seq ? rsp_pkg::START_SEQ : rsp_pkg::START_NONE;
                    res.payload_length = i_job.len;
                end else if (r_idx == 2'd1) begin
                    res.data = i_job.seq0;
                end else begin
                    res.data = i_job.seq1;
                end
            end
            default: begin
                res.data = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (load) begin
                r_out_vld <= 1'b1;
                r_idx     <= (r_idx == last_idx) ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= res;
        end
    end

endmodule

// ----- hw/rtl/rsp_packet_receiver.sv -----
// rsp_packet_receiver: top level of the remote serial protocol receive side
// depends on rsp_pkg, rsp_front, rsp_job_fifo and rsp_back
//
//   port group           direction  handshake          payload
//   received items       in         push / full        i_in_item  (rsp_pkg::t_in_item)
//   result transfers     out        pop / empty        o_out_item (rsp_pkg::t_out_item)
//
// one item is taken per cycle; the front stage stalls only when its staged job
// cannot enter the four-entry job queue
// results leave the output register at one per cycle while pop is held and a job
// waits; an accepted packet with a sequence id gives four results, otherwise two
// the first result of an item reaches the result ports through the staged job,
// the job queue and the output register, in that order
// synchronous active-low reset clears control state only; store contents are kept
`timescale 1ns / 1ps

module rsp_packet_receiver (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  rsp_pkg::t_in_item  i_in_item,
    output logic               empty,
    input  logic               pop,
    output rsp_pkg::t_out_item o_out_item
);

    logic          job_vld;
    rsp_pkg::t_job front_job;
    logic          q_full;
    rsp_pkg::t_job head_job;
    logic          q_empty;
    logic          q_pop;

    rsp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_in_item),
        .o_full     (full),
        .o_job_vld  (job_vld),
        .o_job      (front_job),
        .i_job_full (q_full)
    );

    rsp_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_vld),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_empty (q_empty)
    );

    rsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (q_empty),
        .i_job       (head_job),
        .o_job_pop   (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_item      (o_out_item)
    );

endmodule
